// ===== sv/cpu8x_pkg.sv =====
// cpu8x_pkg: shared types and constants for the cpu8 execute block
// no dependencies
`timescale 1ns / 1ps
package cpu8x_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
      OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
      OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
      OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
      OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
      OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
      OP_INX = 6'd24, OP_INY = 6'd25, OP_JMP = 6'd26, OP_LDA = 6'd27,
      OP_LDX = 6'd28, OP_LDY = 6'd29, OP_LSR = 6'd30, OP_NOP = 6'd31,
      OP_ORA = 6'd32, OP_PHA = 6'd33, OP_PHP = 6'd34, OP_PLA = 6'd35,
      OP_ROL = 6'd36, OP_ROR = 6'd37, OP_SEC = 6'd38, OP_SED = 6'd39,
      OP_SEI = 6'd40, OP_STA = 6'd41, OP_STX = 6'd42, OP_STY = 6'd43,
      OP_TAX = 6'd44, OP_TAY = 6'd45, OP_TSX = 6'd46, OP_TXA = 6'd47,
      OP_TXS = 6'd48, OP_TYA = 6'd49
   } op_type;

   localparam logic [7:0] RESET_SP    = 8'hFD;
   localparam logic [7:0] RESET_FLAGS = 8'h24;
   localparam logic [7:0] PUSH_BITS   = 8'h30;
   localparam logic [7:0] STACK_PAGE  = 8'h01;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   typedef struct packed {
      logic [5:0]  req_type;
      logic [7:0]  operand;
      logic [15:0] address;
      logic [15:0] pc;
      logic        to_accumulator;
   } req_type_t_type;

   typedef struct packed {
      logic [7:0]  reg_a_out;
      logic [7:0]  reg_x_out;
      logic [7:0]  reg_y_out;
      logic [7:0]  stack_ptr_out;
      logic [7:0]  flags_out;
      logic [15:0] next_pc;
      logic        write_valid;
      logic [15:0] write_addr;
      logic [7:0]  write_data;
   } rsp_type;

   // front-end classification carried with each queued item
   typedef struct packed {
      op_type      op;
      logic        is_branch;
      logic        is_shift;
      logic        shift_mem;
      logic [15:0] branch_target;
      logic [7:0]  operand;
      logic [15:0] address;
      logic [15:0] pc;
   } dec_type;

endpackage

// ===== sv/cpu8x_front.sv =====
// cpu8x_front: accepts request beats, classifies them, fills the decoded queue
// depends on cpu8x_pkg
`timescale 1ns / 1ps
module cpu8x_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cpu8x_pkg::req_type_t_type req_data,
   output logic                      q_valid,
   input  logic                      q_stall,
   output cpu8x_pkg::dec_type        q_data
);
   import cpu8x_pkg::*;

   logic    [1:0] count_ff, count_in;
   dec_type       slot_ff [2];
   logic          head_ff, head_in, tail_ff, tail_in;
   dec_type       dec;
   logic          push, pop;
   logic [15:0]   disp;

   always_comb begin
      disp = {{8{req_data.operand[7]}}, req_data.operand};
      dec.op            = (req_data.req_type > 6'd49) ? OP_NOP : op_type'(req_data.req_type);
      dec.is_branch     = (dec.op inside {OP_BCC, OP_BCS, OP_BEQ, OP_BMI,
                                          OP_BNE, OP_BPL, OP_BVC, OP_BVS});
      dec.is_shift      = (dec.op inside {OP_ASL, OP_LSR, OP_ROL, OP_ROR});
      dec.shift_mem     = dec.is_shift && !req_data.to_accumulator;
      dec.branch_target = req_data.pc + disp;
      dec.operand       = req_data.operand;
      dec.address       = req_data.address;
      dec.pc            = req_data.pc;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && !q_stall;
   assign q_data    = slot_ff[head_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff ^ pop;
      tail_in  = tail_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      if (push) slot_ff[tail_ff] <= dec;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count missed a pop");
endmodule

// ===== sv/cpu8x_back.sv =====
// cpu8x_back: register file, alu and flag update, output register
// depends on cpu8x_pkg
`timescale 1ns / 1ps
module cpu8x_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_stall,
   input  cpu8x_pkg::dec_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cpu8x_pkg::rsp_type rsp_data
);
   import cpu8x_pkg::*;

   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       fire;
   logic [7:0] m, src, res, nz_val;
   logic [8:0] sum;
   logic       set_nz, take;

   assign q_stall   = out_valid_ff && rsp_stall;
   assign fire      = q_valid && !q_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      m      = q_data.operand;
      a_in   = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; p_in = p_ff;
      set_nz = 1'b0; nz_val = 8'd0; take = 1'b0;
      src    = q_data.shift_mem ? m : a_ff;
      res    = 8'd0;
      sum    = {1'b0, a_ff} + {1'b0, m} + {8'd0, p_ff[FLAG_C]};
      out_in = '0;
      out_in.next_pc = q_data.pc;
      unique case (q_data.op)
         OP_ADC: begin
            p_in[FLAG_V] = ~(a_ff[7] ^ m[7]) & (a_ff[7] ^ sum[7]);
            p_in[FLAG_C] = sum[8];
            a_in = sum[7:0]; set_nz = 1'b1; nz_val = sum[7:0];
         end
         OP_AND: begin a_in = a_ff & m; set_nz = 1'b1; nz_val = a_in; end
         OP_EOR: begin a_in = a_ff ^ m; set_nz = 1'b1; nz_val = a_in; end
         OP_ORA: begin a_in = a_ff | m; set_nz = 1'b1; nz_val = a_in; end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            case (q_data.op)
               OP_ASL:  res = {src[6:0], 1'b0};
               OP_LSR:  res = {1'b0, src[7:1]};
               OP_ROL:  res = {src[6:0], p_ff[FLAG_C]};
               default: res = {p_ff[FLAG_C], src[7:1]};
            endcase
            p_in[FLAG_C] = (q_data.op == OP_ASL || q_data.op == OP_ROL) ? src[7] : src[0];
            set_nz = 1'b1; nz_val = res;
            if (q_data.shift_mem) begin
               out_in.write_valid = 1'b1;
               out_in.write_addr  = q_data.address;
               out_in.write_data  = res;
            end else a_in = res;
         end
         OP_BCC: take = !p_ff[FLAG_C];
         OP_BCS: take = p_ff[FLAG_C];
         OP_BEQ: take = p_ff[FLAG_Z];
         OP_BNE: take = !p_ff[FLAG_Z];
         OP_BMI: take = p_ff[FLAG_N];
         OP_BPL: take = !p_ff[FLAG_N];
         OP_BVC: take = !p_ff[FLAG_V];
         OP_BVS: take = p_ff[FLAG_V];
         OP_BIT: begin
            p_in[FLAG_N] = m[7]; p_in[FLAG_V] = m[6];
            p_in[FLAG_Z] = ((a_ff & m) == 8'd0);
         end
         OP_CLC: p_in[FLAG_C] = 1'b0;
         OP_CLD: p_in[FLAG_D] = 1'b0;
         OP_CLI: p_in[FLAG_I] = 1'b0;
         OP_CLV: p_in[FLAG_V] = 1'b0;
         OP_SEC: p_in[FLAG_C] = 1'b1;
         OP_SED: p_in[FLAG_D] = 1'b1;
         OP_SEI: p_in[FLAG_I] = 1'b1;
         OP_CMP, OP_CPX, OP_CPY: begin
            res = (q_data.op == OP_CMP) ? a_ff : (q_data.op == OP_CPX) ? x_ff : y_ff;
            set_nz = 1'b1; nz_val = res - m;
            p_in[FLAG_C] = (res >= m);
         end
         OP_DEC, OP_INC: begin
            res = (q_data.op == OP_DEC) ? m - 8'd1 : m + 8'd1;
            set_nz = 1'b1; nz_val = res;
            out_in.write_valid = 1'b1;
            out_in.write_addr  = q_data.address;
            out_in.write_data  = res;
         end
         OP_DEX: begin x_in = x_ff - 8'd1; set_nz = 1'b1; nz_val = x_in; end
         OP_DEY: begin y_in = y_ff - 8'd1; set_nz = 1'b1; nz_val = y_in; end
         OP_INX: begin x_in = x_ff + 8'd1; set_nz = 1'b1; nz_val = x_in; end
         OP_INY: begin y_in = y_ff + 8'd1; set_nz = 1'b1; nz_val = y_in; end
         OP_JMP: out_in.next_pc = q_data.address;
         OP_LDA: begin a_in = m; set_nz = 1'b1; nz_val = m; end
         OP_LDX: begin x_in = m; set_nz = 1'b1; nz_val = m; end
         OP_LDY: begin y_in = m; set_nz = 1'b1; nz_val = m; end
         OP_PHA, OP_PHP: begin
            out_in.write_valid = 1'b1;
            out_in.write_addr  = {STACK_PAGE, sp_ff};
            out_in.write_data  = (q_data.op == OP_PHA) ? a_ff : (p_ff | PUSH_BITS);
            sp_in = sp_ff - 8'd1;
         end
         OP_PLA: begin sp_in = sp_ff + 8'd1; a_in = m; set_nz = 1'b1; nz_val = m; end
         OP_STA, OP_STX, OP_STY: begin
            out_in.write_valid = 1'b1;
            out_in.write_addr  = q_data.address;
            out_in.write_data  = (q_data.op == OP_STA) ? a_ff :
                                 (q_data.op == OP_STX) ? x_ff : y_ff;
         end
         OP_TAX: begin x_in = a_ff; set_nz = 1'b1; nz_val = a_ff; end
         OP_TAY: begin y_in = a_ff; set_nz = 1'b1; nz_val = a_ff; end
         OP_TSX: begin x_in = sp_ff; set_nz = 1'b1; nz_val = sp_ff; end
         OP_TXA: begin a_in = x_ff; set_nz = 1'b1; nz_val = x_ff; end
         OP_TXS: sp_in = x_ff;
         OP_TYA: begin a_in = y_ff; set_nz = 1'b1; nz_val = y_ff; end
         default: ;
      endcase
      if (set_nz) begin
         p_in[FLAG_N] = nz_val[7];
         p_in[FLAG_Z] = (nz_val == 8'd0);
      end
      if (q_data.is_branch && take) out_in.next_pc = q_data.branch_target;
      out_in.reg_a_out     = a_in;
      out_in.reg_x_out     = x_in;
      out_in.reg_y_out     = y_in;
      out_in.stack_ptr_out = sp_in;
      out_in.flags_out     = p_in;
      out_valid_in = fire || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0;
         sp_ff <= RESET_SP; p_ff <= RESET_FLAGS;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in; p_ff <= p_in;
         end
      end
      if (fire) out_ff <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid && rsp_data.flags_out == p_ff)
      else $error("result flags differ from register file");
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> a_ff == $past(a_ff) && sp_ff == $past(sp_ff))
      else $error("registers changed without an item");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_valid |-> rsp_data.write_addr == 16'd0)
      else $error("write address set without a write");
endmodule

// ===== sv/cpu8_instruction_execute.sv =====
// cpu8_instruction_execute: execute stage of an 8-bit processor core
// depends on cpu8x_pkg, cpu8x_front, cpu8x_back
//
// usage: each req beat carries one decoded operation with its operand byte,
// effective address and program counter. each beat yields exactly one rsp
// beat holding A, X, Y, SP and status after the operation, the next program
// counter and at most one memory or stack write.
// path: a beat accepted on req is classified and written into a two-entry queue,
// leaves it when the back end takes it, and its result is held in the output
// register that drives rsp.
// throughput: one beat per cycle while rsp_stall does not hold the output register,
// set by the alu and register file update in the back end.
// reset: A, X, Y clear, SP goes to 0xFD, status to 0x24, queue and output
// register empty.
// stall: when rsp_stall holds, the output register keeps its beat, the back
// end pauses and the queue fills; req_stall rises once both entries are full.
`timescale 1ns / 1ps
module cpu8_instruction_execute (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cpu8x_pkg::req_type_t_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cpu8x_pkg::rsp_type        rsp_data
);
   import cpu8x_pkg::*;

   logic    q_valid, q_stall;
   dec_type q_data;

   cpu8x_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_stall, .q_data
   );

   cpu8x_back u_back (
      .clock, .reset, .q_valid, .q_stall, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
